// ===== sv/sabs_pkg.sv =====
package sabs_pkg;

   // field widths of the request and response words
   localparam int IDX_W = 10;
   localparam int VAL_W = 32;

   // range bounds carry one extra bit: the upper bound is held as right + 1
   localparam int POS_W = IDX_W + 1;

   // default store depth
   localparam int STORE_DEPTH_DEFAULT = 1024;

   // operation codes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef logic signed [VAL_W-1:0] value_type;
   typedef logic [IDX_W-1:0]        index_type;
   typedef logic [POS_W-1:0]        pos_type;

endpackage

// ===== sv/sabs_ram.sv =====
module sabs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== sv/sorted_array_binary_search.sv =====
// Binary search over a store of signed 32-bit entries that software writes
// in ascending order.
// Request channel (req_valid / req_stall): req_operation selects a write,
// which places req_item_value at req_element_index, or a search for the key
// req_item_value over the inclusive range req_search_left..req_search_right.
// A write with an index beyond the store is dropped; an upper bound beyond
// the store is lowered to its last entry.
// Response channel (rsp_valid / rsp_stall): one word per search, none per
// write. rsp_found flags a match, rsp_match_index is its index, 0 otherwise.
// A write does not hold off the next request. A search issues its first store
// read in the cycle it is accepted, probes at most floor(log2(range)) + 1
// midpoints and holds off requests until it finishes; an empty range answers
// without probing. The single read port of the store sets the pace: one
// midpoint per cycle.
// The response sits in an output register, so a write may be accepted while
// a response waits; a search that finishes while the response register is
// still stalled parks its result and holds off requests until it moves out.
// Reset clears the control state only; store entries are undefined until
// written and a search must not probe an unwritten entry.
module sorted_array_binary_search #(
   parameter int STORE_DEPTH = sabs_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_operation,
   input  logic [sabs_pkg::IDX_W-1:0] req_element_index,
   input  logic signed [sabs_pkg::VAL_W-1:0] req_item_value,
   input  logic [sabs_pkg::IDX_W-1:0] req_search_left,
   input  logic [sabs_pkg::IDX_W-1:0] req_search_right,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_found,
   output logic [sabs_pkg::IDX_W-1:0] rsp_match_index
);

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int WIDE_W = (ADDR_W + 1 > sabs_pkg::POS_W) ? ADDR_W + 1 : sabs_pkg::POS_W;
   localparam logic [WIDE_W-1:0] LAST_ENTRY = WIDE_W'(STORE_DEPTH - 1);
   localparam logic [WIDE_W-1:0] DEPTH_WIDE = WIDE_W'(STORE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   sabs_pkg::pos_type   lo_ff, lo_in;
   sabs_pkg::pos_type   hip1_ff, hip1_in;
   sabs_pkg::pos_type   mid_ff, mid_in;
   sabs_pkg::value_type key_ff, key_in;
   logic                res_found_ff, res_found_in;
   sabs_pkg::index_type res_index_ff, res_index_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   sabs_pkg::index_type rsp_index_ff, rsp_index_in;

   logic                out_free;
   logic                finish;
   logic                finish_found;
   sabs_pkg::index_type finish_index;
   logic                wr_en;
   logic                rd_en;
   logic [WIDE_W-1:0]   wr_wide;
   logic [WIDE_W-1:0]   right_wide;
   logic [WIDE_W-1:0]   right_clamp;
   logic [WIDE_W-1:0]   mid_wide;
   sabs_pkg::pos_type   lo_next;
   sabs_pkg::pos_type   hip1_next;
   logic [sabs_pkg::VAL_W-1:0] rd_data;
   sabs_pkg::value_type entry;

   // midpoint of lo..hip1-1, rounded down; caller ensures lo < hip1
   function automatic sabs_pkg::pos_type mid_of(sabs_pkg::pos_type lo,
                                                sabs_pkg::pos_type hip1);
      sabs_pkg::pos_type span;
      span = hip1 - lo - sabs_pkg::POS_W'(1);
      return lo + (span >> 1);
   endfunction

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign wr_wide     = WIDE_W'(req_element_index);
   assign right_wide  = WIDE_W'(req_search_right);
   assign right_clamp = (right_wide > LAST_ENTRY) ? LAST_ENTRY : right_wide;
   assign entry       = $signed(rd_data);

   // next bounds after a probe that missed
   always_comb begin
      lo_next   = lo_ff;
      hip1_next = hip1_ff;
      if (entry < key_ff) begin
         lo_next = mid_ff + sabs_pkg::POS_W'(1);
      end else begin
         hip1_next = mid_ff;
      end
   end

   // search sequencer
   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hip1_in      = hip1_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      res_found_in = res_found_ff;
      res_index_in = res_index_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      finish       = 1'b0;
      finish_found = 1'b0;
      finish_index = '0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == sabs_pkg::OP_WRITE) begin
                  wr_en = (wr_wide < DEPTH_WIDE);
               end else begin
                  key_in  = req_item_value;
                  lo_in   = sabs_pkg::POS_W'(req_search_left);
                  hip1_in = sabs_pkg::POS_W'(right_clamp) + sabs_pkg::POS_W'(1);
                  if (lo_in < hip1_in) begin
                     mid_in   = mid_of(lo_in, hip1_in);
                     rd_en    = 1'b1;
                     state_in = ST_PROBE;
                  end else begin
                     finish = 1'b1;
                  end
               end
            end
         end
         ST_PROBE: begin
            if (entry == key_ff) begin
               finish       = 1'b1;
               finish_found = 1'b1;
               finish_index = mid_ff[sabs_pkg::IDX_W-1:0];
            end else begin
               lo_in   = lo_next;
               hip1_in = hip1_next;
               if (lo_next < hip1_next) begin
                  mid_in = mid_of(lo_next, hip1_next);
                  rd_en  = 1'b1;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_index_in = res_index_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hand the result to the output register, or park it
      if (finish) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_found_in = finish_found;
            rsp_index_in = finish_index;
            state_in     = ST_IDLE;
         end else begin
            res_found_in = finish_found;
            res_index_in = finish_index;
            state_in     = ST_DONE;
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hip1_ff      <= hip1_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      res_found_ff <= res_found_in;
      res_index_ff <= res_index_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign mid_wide = WIDE_W'(mid_in);

   // entry store
   sabs_ram #(
      .WIDTH(sabs_pkg::VAL_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_wide[ADDR_W-1:0]),
      .wr_data(req_item_value),
      .rd_en  (rd_en),
      .rd_addr(mid_wide[ADDR_W-1:0]),
      .rd_data(rd_data)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_index_ff;

   // a probe only runs on a non-empty range
   a_probe_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (lo_ff < hip1_ff))
      else $error("probe with empty range");

   // the probed midpoint lies inside the range and the store
   a_probe_mid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (mid_ff >= lo_ff && mid_ff < hip1_ff
                                  && WIDE_W'(mid_ff) < DEPTH_WIDE))
      else $error("midpoint outside range");

   // a miss reports index zero
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_index_ff == '0))
      else $error("miss with nonzero index");

   // a parked result waits only while the output register is held
   a_park: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> rsp_valid_ff)
      else $error("result parked with free output");

endmodule

// ===== test/sorted_search_checker.sv =====
module sorted_search_checker
   import sabs_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic      req_stall,
   input  logic      req_operation,
   input  index_type req_element_index,
   input  value_type req_item_value,
   input  index_type req_search_left,
   input  index_type req_search_right,
   input  logic      rsp_valid,
   input  logic      rsp_stall,
   input  logic      rsp_found,
   input  index_type rsp_match_index,
   output int        mismatch_total,
   output int        results_owed
);

   typedef struct packed {
      logic      found;
      index_type index;
   } outcome_type;

   // our own image of the store, filled by accepted write words
   value_type   shadow [STORE_DEPTH];
   outcome_type awaited_results [$];

   // walk the same midpoints the block probes and report where the key sits
   function automatic outcome_type search_outcome(input value_type key, input int lo,
                                                  input int hi);
      outcome_type outcome;
      int mid;
      outcome = '0;
      if (hi > STORE_DEPTH - 1) hi = STORE_DEPTH - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (shadow[mid] == key) begin
            outcome.found = 1'b1;
            outcome.index = index_type'(mid);
            return outcome;
         end
         if (shadow[mid] < key) lo = mid + 1;
         else hi = mid - 1;
      end
      return outcome;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         awaited_results.delete();
         mismatch_total = 0;
         results_owed = 0;
      end else begin
         // response side first: it always answers an older search
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               if (mismatch_total < 10)
                  $display("%0t: response word with no search pending: found %b index %0d",
                           $realtime, rsp_found, rsp_match_index);
               mismatch_total++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_found !== want.found || rsp_match_index !== want.index) begin
                  if (mismatch_total < 10)
                     $display("%0t: found expected %b got %b, index expected %0d got %0d",
                              $realtime, want.found, rsp_found, want.index, rsp_match_index);
                  mismatch_total++;
               end
            end
         end
         // request side: writes update the image, searches queue an outcome
         if (req_valid && !req_stall) begin
            if (req_operation == OP_WRITE) begin
               if (req_element_index < STORE_DEPTH) shadow[req_element_index] = req_item_value;
            end else begin
               awaited_results.push_back(search_outcome(req_item_value, req_search_left,
                                                        req_search_right));
            end
         end
         results_owed = awaited_results.size();
      end
   end

endmodule

// ===== test/sorted_array_binary_search_test.sv =====
module sorted_array_binary_search_test;
   import sabs_pkg::*;

   localparam int DEPTH = STORE_DEPTH_DEFAULT;
   localparam int ITEM_TARGET = 1950;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 24;
   localparam value_type VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam value_type VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

   typedef enum int {FLOWING, COIN_FLIP, MOSTLY_STALLED, ON_OFF} stall_pattern_type;

   logic      clock = 1'b0;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   logic      req_operation;
   index_type req_element_index;
   value_type req_item_value;
   index_type req_search_left;
   index_type req_search_right;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   logic      rsp_found;
   index_type rsp_match_index;
   int        mismatch_total;
   int        results_owed;

   // what the stimulus has laid into the store, used to pick keys and safe ranges
   value_type store_image [DEPTH];
   bit        written [DEPTH];
   int        items_sent = 0;
   int        burst_left = 0;
   int        idle_cycles = 0;
   int        stall_left = 0;
   stall_pattern_type stall_pattern = FLOWING;

   sorted_array_binary_search #(.STORE_DEPTH(DEPTH)) dut (.*);

   sorted_search_checker #(.STORE_DEPTH(DEPTH)) search_check (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // response stall follows a pattern, picked at random each time its countdown runs out
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_pattern <= stall_pattern_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(8, 64);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_pattern)
         FLOWING:        rsp_stall <= 1'b0;
         COIN_FLIP:      rsp_stall <= 1'($urandom_range(0, 1));
         MOSTLY_STALLED: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:        rsp_stall <= stall_left[2];
      endcase
   end

   // watchdog on cycles in which neither channel moves a word
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // present one word, idling first when the current burst is used up
   task automatic send_word(input logic op, input index_type idx, input value_type val,
                            input index_type lo, input index_type hi);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(40, 160);
         else burst_left = $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_operation <= op;
      req_element_index <= idx;
      req_item_value <= val;
      req_search_left <= lo;
      req_search_right <= hi;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // fields a word does not use carry noise
   task automatic put_entry(input int idx, input value_type val);
      store_image[idx] = val;
      written[idx] = 1'b1;
      send_word(OP_WRITE, index_type'(idx), val, index_type'($urandom), index_type'($urandom));
   endtask

   task automatic seek(input value_type key, input int lo, input int hi);
      send_word(OP_SEARCH, index_type'($urandom), key, index_type'(lo), index_type'(hi));
   endtask

   function automatic bit span_written(input int lo, input int hi);
      for (int i = lo; i <= hi; i++)
         if (!written[i]) return 1'b0;
      return 1'b1;
   endfunction

   // mostly a key that sits in the range, sometimes a neighbor or pure noise
   function automatic value_type pick_key(input int lo, input int hi);
      value_type key;
      int pick;
      key = store_image[$urandom_range(lo, hi)];
      pick = $urandom_range(0, 9);
      if (pick >= 8) key = $urandom;
      else if (pick == 7) key = key + 1;
      else if (pick == 6) key = key - 1;
      return key;
   endfunction

   initial begin
      int run_base;
      int run_last;
      int lo;
      int hi;
      int kind;
      value_type v;
      index_type idx_bits;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= OP_WRITE;
      req_element_index <= '0;
      req_item_value <= '0;
      req_search_left <= '0;
      req_search_right <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extreme values, both ends of the store, upper bound zero
      put_entry(0, VAL_MIN);
      put_entry(1, -1);
      put_entry(2, 0);
      put_entry(3, 1);
      put_entry(4, 100);
      put_entry(5, VAL_MAX);
      put_entry(DEPTH - 2, 0);
      put_entry(DEPTH - 1, VAL_MAX);
      seek(VAL_MIN, 0, 5);
      seek(VAL_MAX, 0, 5);
      seek(0, 0, 5);
      seek(50, 0, 5);
      seek(VAL_MIN + 1, 0, 5);
      seek(VAL_MIN, 0, 0);
      seek(7, 0, 0);
      // empty ranges give a miss without probing; then one- and two-entry ranges at the top
      seek(-1, 5, 2);
      seek(VAL_MAX, DEPTH - 1, 0);
      seek(VAL_MAX, DEPTH - 1, DEPTH - 1);
      seek(VAL_MAX, DEPTH - 2, DEPTH - 1);
      // break the ascending order and search through it
      put_entry(3, -1000);
      seek(-1000, 0, 5);
      seek(100, 0, 5);

      // random: lay an ascending run, then search in and around it
      while (items_sent < ITEM_TARGET) begin
         run_base = $urandom_range(0, DEPTH - 1);
         run_last = run_base + $urandom_range(0, 47);
         if (run_last > DEPTH - 1) run_last = DEPTH - 1;
         for (int i = run_base; i <= run_last; i++) begin
            // the index sets the top bits, so values ascend across the whole store
            idx_bits = index_type'(i);
            v = {~idx_bits[IDX_W-1], idx_bits[IDX_W-2:0], (VAL_W-IDX_W)'($urandom)};
            if (i > run_base && $urandom_range(0, 7) == 0) v = store_image[i - 1];
            put_entry(i, v);
         end
         // stray write that can leave the store out of order
         if ($urandom_range(0, 3) == 0) put_entry($urandom_range(0, DEPTH - 1), $urandom);

         repeat ($urandom_range(4, 40)) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
               lo = $urandom_range(1, DEPTH - 1);
               hi = $urandom_range(0, lo - 1);
               seek($urandom, lo, hi);
            end else begin
               // a wide range only when every entry in it has been laid
               lo = $urandom_range(0, DEPTH - 1);
               hi = $urandom_range(lo, DEPTH - 1);
               if (kind > 2 || !span_written(lo, hi)) begin
                  lo = $urandom_range(run_base, run_last);
                  hi = $urandom_range(lo, run_last);
                  if (kind == 3) begin
                     lo = run_base;
                     hi = run_last;
                  end
               end
               seek(pick_key(lo, hi), lo, hi);
            end
         end
      end

      // drain outstanding results, then leave room for anything extra
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_total == 0 && results_owed == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
